@@ rtl/core/ncd_pkg.sv @@
// ----------------------------------------------------------------------------
// ncd_pkg
// Shared types and constants for the negative cycle detector.
// ----------------------------------------------------------------------------
package ncd_pkg;

  // default sizes
  localparam int MAX_NODES_DEF   = 512;
  localparam int MAX_EDGES_DEF   = 4096;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed field widths
  localparam int NODE_ID_W = 9;
  localparam int CFG_W     = 9;
  localparam int CNT_W     = 10;
  localparam int DIST_W    = 32;
  localparam int SUM_W     = 34;

  // request codes
  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_POP,
    S_POP_WAIT,
    S_U_WAIT,
    S_E_RD,
    S_E_CHK,
    S_V_CHK,
    S_DONE
  } state_t;

  // per node record
  typedef struct packed {
    logic                     reached;
    logic                     inq;
    logic [CNT_W-1:0]         cnt;
    logic signed [DIST_W-1:0] path_len;
  } node_t;

endpackage

@@ rtl/core/negative_cycle_detector.sv @@
// ----------------------------------------------------------------------------
// negative_cycle_detector
// Edge list store with a queue based Bellman-Ford negative cycle search.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one request: clear the graph,
// add an edge, or run a check with an offset taken off every edge weight.
// Clear and add give no result. A check gives one result on the
// output channel (out_valid / out_stall): the cycle flag and the sticky
// store-full flag.
// A check first sweeps the node table and queues node 0. Then each node
// taken off the work queue is read and marked as off the queue, and the
// whole edge store is walked; each edge leaving that node reads and may
// update its end node. The search ends when the queue is empty or a node
// has been queued node_count times (at least once); then the result loads.
// in_stall is high from check start until the result is loaded into the
// output register; the result holds there while out_stall is high, and a
// following check waits at its end for the register to free up.
// User writes node_count via node_count_wr_en only while idle; not enforced.
// Reset empties the store, clears the flags and sets node_count to 1.
// ----------------------------------------------------------------------------
module negative_cycle_detector
  import ncd_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          node_count_wr_en,
  input  logic [CFG_W-1:0]              node_count_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [NODE_ID_W-1:0]          src_node,
  input  logic [NODE_ID_W-1:0]          dst_node,
  input  logic signed [WEIGHT_BITS-1:0] edge_weight,
  input  logic signed [WEIGHT_BITS-1:0] offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          negative_cycle,
  output logic                          edge_store_full
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW = $clog2(MAX_EDGES + 1);

  localparam logic signed [SUM_W-1:0] DMAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] DMIN = -SUM_W'(64'sd2147483648);

  // memories
  logic [NW-1:0]          e_src_mem [MAX_EDGES];
  logic [NW-1:0]          e_dst_mem [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] e_cost_mem [MAX_EDGES];
  node_t                  node_mem [MAX_NODES];
  logic [NW-1:0]          q_mem [MAX_NODES];

  state_t state, state_next;

  logic [TW-1:0]                edge_total;
  logic                         overflow_seen;
  logic [CFG_W-1:0]             node_count;
  logic signed [WEIGHT_BITS-1:0] off;
  logic [NW:0]                  clr_idx;
  logic [NW-1:0]                head, tail, u;
  logic [NW:0]                  used;
  logic [TW-1:0]                k;
  logic signed [DIST_W-1:0]     dist_u;
  logic                         found;

  logic [NW-1:0]          e_src_q, e_dst_q;
  logic [WEIGHT_BITS-1:0] e_cost_q;
  node_t                  node_q;
  logic [NW-1:0]          q_q;

  // memory strobes
  logic          e_we, e_re, n_we, n_re, q_we, q_re;
  logic [NW-1:0] n_waddr, n_raddr;
  node_t         n_wdata;

  // request decode
  logic in_acc, add_ok, add_full, node_ok, push, hit;
  logic [CNT_W-1:0] cnt_inc, limit;
  logic signed [SUM_W-1:0] cand_raw, cand;
  logic upd;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign node_ok  = (32'(src_node) < MAX_NODES) && (32'(dst_node) < MAX_NODES);
  assign add_full = (32'(edge_total) >= MAX_EDGES);
  assign add_ok   = in_acc && (func == FUNC_ADD) && node_ok && !add_full;
  assign limit    = (node_count == '0) ? CNT_W'(1) : CNT_W'(node_count);

  // relaxation arithmetic
  always_comb begin
    cand_raw = SUM_W'(dist_u) + SUM_W'(signed'(e_cost_q)) - SUM_W'(off);
    if (cand_raw > DMAX) cand = DMAX;
    else if (cand_raw < DMIN) cand = DMIN;
    else cand = cand_raw;
    upd     = !node_q.reached || (cand < SUM_W'(node_q.path_len));
    push    = upd && !node_q.inq;
    cnt_inc = node_q.cnt + CNT_W'(1);
    hit     = push && (cnt_inc == limit);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    e_we = 1'b0; e_re = 1'b0;
    n_we = 1'b0; n_re = 1'b0;
    q_we = 1'b0; q_re = 1'b0;
    n_waddr = '0; n_raddr = '0;
    n_wdata = '0;
    unique case (state)
      S_IDLE: begin
        e_we = add_ok;
        if (in_acc && func == FUNC_CHECK) state_next = S_CLEAR;
      end
      S_CLEAR: begin
        n_we = 1'b1;
        if (32'(clr_idx) == MAX_NODES) begin
          n_waddr = '0;
          n_wdata = '{reached: 1'b1, inq: 1'b1, cnt: '0, path_len: '0};
          q_we = 1'b1;
          state_next = S_POP;
        end else begin
          n_waddr = clr_idx[NW-1:0];
        end
      end
      S_POP: begin
        if (used == '0) state_next = S_DONE;
        else begin
          q_re = 1'b1;
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        n_re = 1'b1;
        n_raddr = q_q;
        state_next = S_U_WAIT;
      end
      S_U_WAIT: begin
        n_we = 1'b1;
        n_waddr = u;
        n_wdata = node_q;
        n_wdata.inq = 1'b0;
        state_next = S_E_RD;
      end
      S_E_RD: begin
        if (k == edge_total) state_next = S_POP;
        else begin
          e_re = 1'b1;
          state_next = S_E_CHK;
        end
      end
      S_E_CHK: begin
        if (e_src_q == u) begin
          n_re = 1'b1;
          n_raddr = e_dst_q;
          state_next = S_V_CHK;
        end else begin
          state_next = S_E_RD;
        end
      end
      S_V_CHK: begin
        n_waddr = e_dst_q;
        n_wdata = node_q;
        if (upd) begin
          n_we = 1'b1;
          n_wdata.path_len = DIST_W'(cand);
          n_wdata.reached = 1'b1;
          if (push) begin
            n_wdata.inq = 1'b1;
            n_wdata.cnt = cnt_inc;
            q_we = 1'b1;
          end
        end
        state_next = hit ? S_DONE : S_E_RD;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // edge store
  always_ff @(posedge clk) begin
    if (e_we) begin
      e_src_mem[edge_total[EW-1:0]]  <= NW'(src_node);
      e_dst_mem[edge_total[EW-1:0]]  <= NW'(dst_node);
      e_cost_mem[edge_total[EW-1:0]] <= edge_weight;
    end
    if (e_re) begin
      e_src_q  <= e_src_mem[k[EW-1:0]];
      e_dst_q  <= e_dst_mem[k[EW-1:0]];
      e_cost_q <= e_cost_mem[k[EW-1:0]];
    end
  end

  // node table
  always_ff @(posedge clk) begin
    if (n_we) node_mem[n_waddr] <= n_wdata;
    if (n_re) node_q <= node_mem[n_raddr];
  end

  // work queue
  always_ff @(posedge clk) begin
    if (q_we) q_mem[tail] <= (state == S_CLEAR) ? '0 : e_dst_q;
    if (q_re) q_q <= q_mem[head];
  end

  // graph state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total    <= '0;
      overflow_seen <= 1'b0;
      node_count    <= CFG_W'(1);
    end else begin
      if (node_count_wr_en) node_count <= node_count_wr_data;
      if (in_acc && func == FUNC_CLEAR) begin
        edge_total    <= '0;
        overflow_seen <= 1'b0;
      end
      if (add_ok) edge_total <= edge_total + TW'(1);
      if (in_acc && func == FUNC_ADD && node_ok && add_full) overflow_seen <= 1'b1;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      head    <= '0;
      tail    <= '0;
      used    <= '0;
      k       <= '0;
      found   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          clr_idx <= '0;
          head    <= '0;
          tail    <= '0;
          used    <= '0;
          off     <= offset;
          found   <= 1'b0;
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + (NW+1)'(1);
          if (32'(clr_idx) == MAX_NODES) begin
            head <= '0;
            tail <= (MAX_NODES == 1) ? '0 : NW'(1);
            used <= (NW+1)'(1);
          end
        end
        S_POP: begin
          if (used != '0) begin
            head <= (32'(head) == MAX_NODES - 1) ? '0 : head + NW'(1);
            used <= used - (NW+1)'(1);
          end
        end
        S_POP_WAIT: u <= q_q;
        S_U_WAIT: begin
          dist_u <= node_q.path_len;
          k      <= '0;
        end
        S_E_CHK: if (e_src_q != u) k <= k + TW'(1);
        S_V_CHK: begin
          k <= k + TW'(1);
          if (upd && e_dst_q == u) dist_u <= DIST_W'(cand);
          if (push) begin
            tail <= (32'(tail) == MAX_NODES - 1) ? '0 : tail + NW'(1);
            used <= used + (NW+1)'(1);
          end
          if (hit) found <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid       <= 1'b1;
        negative_cycle  <= found;
        edge_store_full <= overflow_seen;
      end
    end
  end

endmodule

@@ tb/tb_negative_cycle_detector.sv @@
// ----------------------------------------------------------------------------
// tb_negative_cycle_detector
// Self-checking bench for the negative cycle detector. It drives clear, add
// and check requests on the input channel, predicts each check outcome with
// its own queue based Bellman-Ford search over a copy of the edge list, and
// compares every result with the oldest prediction. Sender gaps and receiver
// stalls vary from phase to phase, as does the node count register.
// ----------------------------------------------------------------------------
module tb_negative_cycle_detector
  import ncd_pkg::*;
;

  typedef struct {
    func_t                    op;
    logic [NODE_ID_W-1:0]     src;
    logic [NODE_ID_W-1:0]     dst;
    logic signed [15:0]       wgt;
    logic signed [15:0]       off;
  } request_t;

  typedef struct {
    logic cyc;
    logic full;
  } verdict_t;

  // graph copy, cycle search and store of pending verdicts
  class cycle_scoreboard;
    logic [8:0]  e_src [4096];
    logic [8:0]  e_dst [4096];
    logic [15:0] e_wgt [4096];
    int          n_edges;
    bit          dropped;
    int          enq_limit;
    verdict_t    pending [$];
    int          mismatches;

    function void set_limit(int v);
      enq_limit = v;
    endfunction

    function bit find_cycle(longint off);
      int     lim;
      longint best [512];
      bit     seen [512];
      bit     inq [512];
      int     cnt [512];
      int     work [$];
      int     u;
      int     v;
      longint cand;
      lim = (enq_limit == 0) ? 1 : enq_limit;
      foreach (seen[i]) begin
        seen[i] = 0;
        inq[i] = 0;
        cnt[i] = 0;
        best[i] = 0;
      end
      seen[0] = 1;
      inq[0] = 1;
      work.insert(work.size(), 0);
      while (work.size() != 0) begin
        u = work.pop_front();
        inq[u] = 0;
        // edges out of u in insertion order
        for (int e = 0; e < n_edges; e++) begin
          if (e_src[e] == u) begin
            v = e_dst[e];
            cand = best[u] + longint'($signed(e_wgt[e])) - off;
            if (cand > 64'sd2147483647) cand = 64'sd2147483647;
            if (cand < -64'sd2147483648) cand = -64'sd2147483648;
            if (!seen[v] || cand < best[v]) begin
              best[v] = cand;
              seen[v] = 1;
              if (!inq[v]) begin
                work.insert(work.size(), v);
                inq[v] = 1;
                cnt[v]++;
                if (cnt[v] == lim) return 1;
              end
            end
          end
        end
      end
      return 0;
    endfunction

    function void note_request(request_t r);
      verdict_t x;
      case (r.op)
        FUNC_CLEAR: begin
          n_edges = 0;
          dropped = 0;
        end
        FUNC_ADD: begin
          if (n_edges >= 4096) begin
            dropped = 1;
          end else begin
            e_src[n_edges] = r.src;
            e_dst[n_edges] = r.dst;
            e_wgt[n_edges] = r.wgt;
            n_edges++;
          end
        end
        FUNC_CHECK: begin
          x.cyc = find_cycle(longint'(r.off));
          x.full = dropped;
          pending.insert(pending.size(), x);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic cyc, logic full);
      verdict_t x;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: cycle=%b full=%b", cyc, full);
        return;
      end
      x = pending.pop_front();
      if (cyc !== x.cyc || full !== x.full) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected cycle=%b full=%b, got cycle=%b full=%b",
                   x.cyc, x.full, cyc, full);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                node_count_wr_en;
  logic [CFG_W-1:0]    node_count_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          func;
  logic [NODE_ID_W-1:0] src_node;
  logic [NODE_ID_W-1:0] dst_node;
  logic signed [15:0]  edge_weight;
  logic signed [15:0]  offset;
  logic                out_valid;
  logic                out_stall;
  logic                negative_cycle;
  logic                edge_store_full;

  cycle_scoreboard sb;
  int  idle_pct;
  int  stall_pct;
  int  max_node;

  negative_cycle_detector uut (
    .clk                (clk),
    .rst                (rst),
    .node_count_wr_en   (node_count_wr_en),
    .node_count_wr_data (node_count_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .src_node           (src_node),
    .dst_node           (dst_node),
    .edge_weight        (edge_weight),
    .offset             (offset),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .negative_cycle     (negative_cycle),
    .edge_store_full    (edge_store_full)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(negative_cycle, edge_store_full);
  end

  // one request through the handshake, with a random gap in front
  task automatic send(request_t r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    func        <= r.op;
    src_node    <= r.src;
    dst_node    <= r.dst;
    edge_weight <= r.wgt;
    offset      <= r.off;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic send_req(func_t op, int s, int d, int w, int o);
    request_t r;
    r.op = op;
    r.src = NODE_ID_W'(s);
    r.dst = NODE_ID_W'(d);
    r.wgt = 16'(w);
    r.off = 16'(o);
    send(r);
  endtask

  // drain results, then let the block settle before a register write
  task automatic set_node_count(int v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    node_count_wr_en   <= 1'b1;
    node_count_wr_data <= CFG_W'(v);
    @(posedge clk);
    node_count_wr_en   <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic int pick_node();
    if ($urandom_range(19) == 0) return $urandom_range(511);
    return $urandom_range(max_node - 1);
  endfunction

  function automatic int pick_weight();
    if ($urandom_range(9) == 0) return $urandom_range(65535);
    return $urandom_range(16) - 8;
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(9))
      0:       return $urandom_range(65535);
      1:       return 32767;
      2:       return -32768;
      default: return $urandom_range(6) - 3;
    endcase
  endfunction

  // well formed graph-then-check sequences, mixed with noise
  task automatic run_phase(int n_items, int nodes, int max_adds);
    int      done;
    int      k;
    request_t r;
    done = 0;
    max_node = nodes;
    while (done < n_items) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(3) != 0) begin
          send_req(FUNC_CLEAR, $urandom_range(511), $urandom_range(511),
                   $urandom_range(65535), $urandom_range(65535));
          done++;
        end
        k = $urandom_range(max_adds);
        repeat (k) begin
          send_req(FUNC_ADD, pick_node(), pick_node(), pick_weight(), $urandom_range(65535));
          done++;
        end
        send_req(FUNC_CHECK, $urandom_range(511), $urandom_range(511),
                 $urandom_range(65535), pick_offset());
        done++;
      end else begin
        r.op = func_t'($urandom_range(3));
        r.src = NODE_ID_W'(pick_node());
        r.dst = NODE_ID_W'(pick_node());
        r.wgt = 16'(pick_weight());
        r.off = 16'(pick_offset());
        send(r);
        if (r.op != FUNC_NONE) done++;
      end
    end
  endtask

  initial begin
    int counts [7] = '{4, 511, 1, 9, 3, 6, 2};
    int sizes  [7] = '{190, 60, 150, 200, 200, 200, 140};
    int nodes  [7] = '{6, 2, 6, 8, 5, 6, 4};
    int adds   [7] = '{10, 3, 10, 12, 8, 10, 6};
    sb = new();
    sb.n_edges = 0;
    sb.dropped = 0;
    sb.mismatches = 0;
    sb.enq_limit = 1;
    rst = 1;
    node_count_wr_en = 0;
    node_count_wr_data = 0;
    in_valid = 0;
    func = FUNC_CLEAR;
    src_node = 0;
    dst_node = 0;
    edge_weight = 0;
    offset = 0;
    idle_pct = 0;
    stall_pct = 0;
    max_node = 4;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset value of node count, empty graph and field extremes
    send_req(FUNC_CHECK, 0, 0, 0, 0);
    send_req(FUNC_ADD, 511, 0, -32768, 0);
    send_req(FUNC_ADD, 0, 511, 32767, 0);
    send_req(FUNC_ADD, 0, 1, -5, 0);
    send_req(FUNC_ADD, 1, 0, 2, 0);
    send_req(FUNC_CHECK, 0, 0, 0, 0);
    send_req(FUNC_NONE, 511, 511, -1, -1);
    set_node_count(3);
    send_req(FUNC_CHECK, 0, 0, 0, 0);
    send_req(FUNC_CHECK, 0, 0, 0, -32768);
    send_req(FUNC_CHECK, 0, 0, 0, 32767);
    // zero node count acts as one
    set_node_count(0);
    send_req(FUNC_CHECK, 0, 0, 0, 0);
    send_req(FUNC_CLEAR, 0, 0, 0, 0);
    send_req(FUNC_CHECK, 511, 511, -1, 0);

    // random phases with rotating idle patterns
    for (int p = 0; p < 7; p++) begin
      set_node_count(counts[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      run_phase(sizes[p], nodes[p], adds[p]);
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // watchdog
  initial begin
    #200000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
